[rtl/core/assert_macros.svh]
// Assertion macros for the tokenizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/xnt_pkg.sv]
// ----------------------------------------------------------------------------
// xnt_pkg
// Types and constants of the XML node tokenizer.
// ----------------------------------------------------------------------------
package xnt_pkg;

    localparam int OUT_OFFSET_BITS = 48;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] node_offset;
        logic [31:0] node_length;
        logic [15:0] name_length;
    } out_item_t;

    // node kinds
    localparam logic [2:0] KIND_TEXT    = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_END     = 3'd2;
    localparam logic [2:0] KIND_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_COMMENT = 3'd4;
    localparam logic [2:0] KIND_CDATA   = 3'd5;
    localparam logic [2:0] KIND_PI      = 3'd6;
    localparam logic [2:0] KIND_DOCTYPE = 3'd7;

    // byte classes found by the front part
    typedef struct packed {
        logic lt;
        logic gt;
        logic qmark;
        logic bang;
        logic slash;
        logic dash;
        logic lbrack;
        logic rbrack;
        logic squote;
        logic dquote;
        logic name;
    } byte_class_t;

    // classified item in the queue
    typedef struct packed {
        logic [7:0]  byte_in;
        logic        last;
        byte_class_t cls;
    } cls_item_t;

    function automatic logic is_name_byte(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == "_" || c == ":" ||
               c == "-" || c == "." || c[7];
    endfunction

    // expected bytes of the CDATA prefix after "<!"
    function automatic logic [7:0] cdata_char(input logic [2:0] m);
        logic [7:0] r;
        case (m)
            3'd0: r = "[";
            3'd1: r = "C";
            3'd2: r = "D";
            3'd3: r = "A";
            3'd4: r = "T";
            3'd5: r = "A";
            3'd6: r = "[";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/xnt_front.sv]
// ----------------------------------------------------------------------------
// xnt_front
// Accepts bytes, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module xnt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               flush,
    input  logic               in_valid,
    output logic               in_stall,
    input  xnt_pkg::in_item_t  in_data,
    output logic               q_valid,
    input  logic               q_pop,
    output xnt_pkg::cls_item_t q_data
);
    import xnt_pkg::*;

    cls_item_t  mem_reg [2];
    logic [0:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cls_item_t  cls_w;

    // classify the incoming byte
    always_comb
    begin
        cls_w.byte_in    = in_data.byte_in;
        cls_w.last       = in_data.last;
        cls_w.cls.lt     = in_data.byte_in == "<";
        cls_w.cls.gt     = in_data.byte_in == ">";
        cls_w.cls.qmark  = in_data.byte_in == "?";
        cls_w.cls.bang   = in_data.byte_in == "!";
        cls_w.cls.slash  = in_data.byte_in == "/";
        cls_w.cls.dash   = in_data.byte_in == "-";
        cls_w.cls.lbrack = in_data.byte_in == "[";
        cls_w.cls.rbrack = in_data.byte_in == "]";
        cls_w.cls.squote = in_data.byte_in == 8'h27;
        cls_w.cls.dquote = in_data.byte_in == "\"";
        cls_w.cls.name   = is_name_byte(in_data.byte_in);
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rd_reg];

    // queue pointers
    always_comb
    begin
        wr_next  = wr_reg + 1'(push);
        rd_next  = rd_reg + 1'(q_pop);
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
        if (flush)
        begin
            wr_next  = '0;
            rd_next  = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= cls_w;
    end

endmodule

[rtl/core/xnt_back.sv]
// ----------------------------------------------------------------------------
// xnt_back
// Node state machine: consumes classified bytes and emits node items.
// ----------------------------------------------------------------------------
module xnt_back #(
    parameter int MAX_TEXT    = 4096,
    parameter int OFFSET_BITS = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [OFFSET_BITS-1:0]   base,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  xnt_pkg::cls_item_t       q_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output xnt_pkg::out_item_t       out_data
);
    import xnt_pkg::*;

    typedef enum logic [9:0] {
        M_TEXT     = 10'b0000000001,
        M_TAGSTART = 10'b0000000010,
        M_BANG     = 10'b0000000100,
        M_COMMENT  = 10'b0000001000,
        M_CDATA    = 10'b0000010000,
        M_DOCTYPE  = 10'b0000100000,
        M_PI       = 10'b0001000000,
        M_TAG      = 10'b0010000000,
        M_QUOTE_S  = 10'b0100000000,
        M_QUOTE_D  = 10'b1000000000
    } mode_t;

    localparam logic [3:0] PREFIX_DEAD = 4'd15;
    localparam logic [31:0] MAX_TEXT_W = 32'(MAX_TEXT);

    mode_t                  mode_reg, mode_next;
    logic [31:0]            nb_reg, nb_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [7:0]             p1_reg, p1_next, p2_reg, p2_next;
    logic [3:0]             pfx_reg, pfx_next;
    logic [15:0]            brk_reg, brk_next;
    logic [15:0]            tnb_reg, tnb_next;
    logic                   run_reg, run_next;
    logic                   ov_reg;
    out_item_t              od_reg;

    logic        emit;
    logic [2:0]  ekind;
    logic        etag;
    logic [31:0] nb_inc;
    logic        step;
    logic [2:0]  pm;
    byte_class_t k;
    logic [7:0]  c;

    // the output register frees up when empty or taken
    assign step      = q_valid && (!ov_reg || !out_stall);
    assign q_pop     = step;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign k         = q_data.cls;
    assign c         = q_data.byte_in;
    assign nb_inc    = (nb_reg == '1) ? nb_reg : nb_reg + 32'd1;
    assign pm        = 3'(pfx_reg - 4'd1);

    // per-byte state update
    always_comb
    begin
        mode_next  = mode_reg;
        nb_next    = nb_reg;
        begin_next = begin_reg;
        pfx_next   = pfx_reg;
        brk_next   = brk_reg;
        tnb_next   = tnb_reg;
        run_next   = run_reg;
        emit       = 1'b0;
        ekind      = KIND_TEXT;
        etag       = 1'b0;
        case (mode_reg)
            M_TEXT:
            begin
                if (k.lt)
                begin
                    emit       = (nb_reg != 0);
                    begin_next = pos_reg;
                    nb_next    = 32'd1;
                    mode_next  = M_TAGSTART;
                end
                else
                begin
                    if (nb_reg == 0)
                        begin_next = pos_reg;
                    nb_next = nb_inc;
                    if (nb_inc >= MAX_TEXT_W)
                    begin
                        emit    = 1'b1;
                        nb_next = '0;
                    end
                end
            end
            M_TAGSTART:
            begin
                nb_next = nb_inc;
                if (k.qmark)
                    mode_next = M_PI;
                else if (k.bang)
                begin
                    mode_next = M_BANG;
                    pfx_next  = '0;
                end
                else
                begin
                    mode_next = M_TAG;
                    pfx_next  = {3'b000, k.slash};
                    run_next  = k.slash || k.name;
                    tnb_next  = {15'd0, k.name};
                end
            end
            M_BANG:
            begin
                nb_next = nb_inc;
                if (pfx_reg == 4'd0)
                begin
                    if (k.dash)
                        pfx_next = 4'd1;
                    else if (k.lbrack)
                        pfx_next = 4'd2;
                    else
                    begin
                        brk_next  = '0;
                        mode_next = M_DOCTYPE;
                    end
                end
                else if (pfx_reg == 4'd1)
                begin
                    if (k.dash)
                        mode_next = M_COMMENT;
                    else
                        pfx_next = PREFIX_DEAD;
                end
                else if (pfx_reg <= 4'd7)
                begin
                    if (c == cdata_char(pm))
                    begin
                        if (pm == 3'd6)
                            mode_next = M_CDATA;
                        else
                            pfx_next = pfx_reg + 4'd1;
                    end
                    else
                        pfx_next = PREFIX_DEAD;
                end
            end
            M_COMMENT:
            begin
                nb_next = nb_inc;
                if (k.gt && p1_reg == "-" && p2_reg == "-")
                begin
                    emit = 1'b1; ekind = KIND_COMMENT;
                    nb_next = '0; mode_next = M_TEXT;
                end
            end
            M_CDATA:
            begin
                nb_next = nb_inc;
                if (k.gt && p1_reg == "]" && p2_reg == "]")
                begin
                    emit = 1'b1; ekind = KIND_CDATA;
                    nb_next = '0; mode_next = M_TEXT;
                end
            end
            M_PI:
            begin
                nb_next = nb_inc;
                if (k.gt && p1_reg == "?")
                begin
                    emit = 1'b1; ekind = KIND_PI;
                    nb_next = '0; mode_next = M_TEXT;
                end
            end
            M_DOCTYPE:
            begin
                nb_next = nb_inc;
                if (k.lbrack)
                begin
                    if (brk_reg != '1)
                        brk_next = brk_reg + 16'd1;
                end
                else if (k.rbrack)
                begin
                    if (brk_reg != 0)
                        brk_next = brk_reg - 16'd1;
                end
                else if (k.gt && brk_reg == 0)
                begin
                    emit = 1'b1; ekind = KIND_DOCTYPE;
                    nb_next = '0; mode_next = M_TEXT;
                end
            end
            M_TAG:
            begin
                nb_next = nb_inc;
                if (run_reg)
                begin
                    if (k.name)
                    begin
                        if (tnb_reg != '1)
                            tnb_next = tnb_reg + 16'd1;
                    end
                    else
                        run_next = 1'b0;
                end
                if (k.squote)
                    mode_next = M_QUOTE_S;
                else if (k.dquote)
                    mode_next = M_QUOTE_D;
                else if (k.gt)
                begin
                    emit  = 1'b1;
                    etag  = 1'b1;
                    ekind = (pfx_reg == 4'd1) ? KIND_END :
                            (p1_reg == "/") ? KIND_EMPTY : KIND_START;
                    nb_next = '0; mode_next = M_TEXT;
                end
            end
            M_QUOTE_S:
            begin
                nb_next  = nb_inc;
                run_next = 1'b0;
                if (k.squote)
                    mode_next = M_TAG;
            end
            M_QUOTE_D:
            begin
                nb_next  = nb_inc;
                run_next = 1'b0;
                if (k.dquote)
                    mode_next = M_TAG;
            end
            default:
            begin
                mode_next = M_TEXT;
                nb_next   = '0;
            end
        endcase
        // pending text flush on the final byte
        if (q_data.last && !emit && mode_next == M_TEXT && nb_next != 0)
        begin
            emit  = 1'b1;
            ekind = KIND_TEXT;
            etag  = 1'b0;
        end
    end

    assign p1_next  = c;
    assign p2_next  = p1_reg;
    assign pos_next = pos_reg + OFFSET_BITS'(1);

    // result payload; the flush case reports the counters after this byte
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            od_reg.kind        <= ekind;
            od_reg.node_offset <= 48'(OFFSET_BITS'(
                (ekind == KIND_TEXT && !(mode_reg == M_TEXT && k.lt)) ?
                begin_next : begin_reg));
            od_reg.node_length <= (ekind == KIND_TEXT && !(mode_reg == M_TEXT && k.lt)
                                   && nb_next != 0) ? nb_next :
                                  (mode_reg == M_TEXT && !k.lt) ? nb_inc : nb_next == 0
                                  && mode_reg != M_TEXT ? nb_inc : nb_reg;
            od_reg.name_length <= etag ? tnb_next : 16'd0;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_TEXT;
            nb_reg    <= '0;
            begin_reg <= '0;
            pos_reg   <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            pfx_reg   <= '0;
            brk_reg   <= '0;
            tnb_reg   <= '0;
            run_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (step)
                ov_reg <= emit;
            else if (!out_stall)
                ov_reg <= 1'b0;
            if (cfg_we || (step && q_data.last))
            begin
                mode_reg  <= M_TEXT;
                nb_reg    <= '0;
                begin_reg <= '0;
                pos_reg   <= base;
                p1_reg    <= '0;
                p2_reg    <= '0;
                pfx_reg   <= '0;
                brk_reg   <= '0;
                tnb_reg   <= '0;
                run_reg   <= 1'b0;
            end
            else if (step)
            begin
                mode_reg  <= mode_next;
                nb_reg    <= nb_next;
                begin_reg <= begin_next;
                pos_reg   <= pos_next;
                p1_reg    <= p1_next;
                p2_reg    <= p2_next;
                pfx_reg   <= pfx_next;
                brk_reg   <= brk_next;
                tnb_reg   <= tnb_next;
                run_reg   <= run_next;
            end
        end
    end

endmodule

[rtl/core/xml_node_tokenizer.sv]
// ----------------------------------------------------------------------------
// xml_node_tokenizer
// Byte-serial XML node splitter with a classify front and a node back end.
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_data (byte_in, last)
// out     | output    | out_valid/out_stall | out_data (kind, offsets, lengths)
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (base_offset)
//
// One byte per cycle while no stall holds the flow; a node shows on out_valid
// once the byte that ends it has passed the queue entry and the result register.
// The back end state machine updates once per byte; a stalled result holds
// the back end while the two-entry queue keeps taking bytes until it is full.
// Reset clears all scan state; base_offset resets to zero.
`include "assert_macros.svh"

module xml_node_tokenizer #(
    parameter int MAX_TEXT    = 4096,
    parameter int OFFSET_BITS = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  xnt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output xnt_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [47:0]        cfg_data
);
    import xnt_pkg::*;

    logic [OFFSET_BITS-1:0] base_reg;
    logic                   cfg_we;
    logic                   q_valid, q_pop;
    cls_item_t              q_data;
    logic [OFFSET_BITS-1:0] cfg_ext;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_ext   = OFFSET_BITS'({{(64 - OUT_OFFSET_BITS){1'b0}}, cfg_data});

    // base offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (cfg_we)
            base_reg <= cfg_ext;
    end

    xnt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (cfg_we),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    xnt_back #(
        .MAX_TEXT    (MAX_TEXT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .base      (cfg_we ? cfg_ext : base_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `ASSERT_IMPL(a_pop_valid, clk, rst_n, q_pop, q_valid)
    `ASSERT_IMPL(a_pop_room, clk, rst_n, q_pop && out_valid, !out_stall)

endmodule
